### rtl/core/env_sensor_compensation_macros.svh
// Assertion macros used by the sensor compensation top level.
`ifndef ENV_SENSOR_COMPENSATION_MACROS_SVH
`define ENV_SENSOR_COMPENSATION_MACROS_SVH

// Check that a condition implies a consequence in the same cycle, or a delayed sequence.
`define ESC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition never holds.
`define ESC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/core/esc_pkg.sv
// Types, constants and helpers shared by the sensor compensation pipeline.
`default_nettype none
package esc_pkg;

  localparam int FRONT_STAGES = 11;
  localparam int DIV_STEPS    = 64;
  localparam int POST_STAGES  = 7;
  localparam int ESC_LATENCY  = FRONT_STAGES + DIV_STEPS + POST_STAGES;

  typedef enum logic [2:0] {
    REG_TEMP    = 3'd0,
    REG_PRES_LO = 3'd1,
    REG_PRES_HI = 3'd2,
    REG_PRES_P9 = 3'd3,
    REG_HUM     = 3'd4
  } esc_reg_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [11:0] h4;
    logic [11:0] h5;
    logic [7:0]  h6;
  } esc_coef_t;

  // Divider working set: partial remainder, shifting dividend/quotient, divisor
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] dvs;
  } esc_div_t;

  // Data that rides alongside the divide
  typedef struct packed {
    logic [15:0] temp;
    logic [31:0] hvv;
    logic [31:0] hm;
    logic        neg;
    logic        zero;
  } esc_side_t;

  function automatic logic [31:0] sx32_16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx32_12(input logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

  function automatic logic [31:0] sx32_8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [63:0] sx64_16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // Saturate a 32-bit signed value to 16 bits
  function automatic logic [15:0] sat_s16(input logic [31:0] v);
    logic [15:0] r;
    if ($signed(v) < -32'sd32768) begin
      r = 16'h8000;
    end else if ($signed(v) > 32'sd32767) begin
      r = 16'h7fff;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/core/esc_div_cell.sv
// One restoring divide cell: retires one quotient bit per item per cycle.
`default_nettype none
module esc_div_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              vld_i,
  input  wire esc_pkg::esc_div_t div_i,
  input  wire esc_pkg::esc_side_t side_i,
  output logic                   vld_o,
  output esc_pkg::esc_div_t      div_o,
  output esc_pkg::esc_side_t     side_o
);
  import esc_pkg::*;

  logic        vld_r;
  esc_div_t    div_r;
  esc_side_t   side_r;
  logic [63:0] shifted;
  logic [64:0] trial;
  logic        fits;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    shifted = {div_i.rem[62:0], div_i.quo[63]};
    trial   = {1'b0, shifted} - {1'b0, div_i.dvs};
    fits    = ~trial[64];
  end

  // Advance valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    div_r.rem <= fits ? trial[63:0] : shifted;
    div_r.quo <= {div_i.quo[62:0], fits};
    div_r.dvs <= div_i.dvs;
    side_r    <= side_i;
  end

  assign vld_o  = vld_r;
  assign div_o  = div_r;
  assign side_o = side_r;

endmodule
`default_nettype wire

### rtl/core/esc_divider.sv
// Chain of divide cells forming a fully pipelined 64-bit unsigned divider.
`default_nettype none
module esc_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              vld_i,
  input  wire esc_pkg::esc_div_t div_i,
  input  wire esc_pkg::esc_side_t side_i,
  output logic                   vld_o,
  output esc_pkg::esc_div_t      div_o,
  output esc_pkg::esc_side_t     side_o
);
  import esc_pkg::*;

  logic              vld_w  [0:DIV_STEPS];
  esc_div_t          div_w  [0:DIV_STEPS];
  esc_side_t         side_w [0:DIV_STEPS];

  assign vld_w[0]  = vld_i;
  assign div_w[0]  = div_i;
  assign side_w[0] = side_i;

  // One cell per quotient bit, MSB first
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    esc_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (vld_w[i]),
      .div_i  (div_w[i]),
      .side_i (side_w[i]),
      .vld_o  (vld_w[i+1]),
      .div_o  (div_w[i+1]),
      .side_o (side_w[i+1])
    );
  end

  assign vld_o  = vld_w[DIV_STEPS];
  assign div_o  = div_w[DIV_STEPS];
  assign side_o = side_w[DIV_STEPS];

endmodule
`default_nettype wire

### rtl/core/esc_front.sv
// Front pipeline: temperature, pressure dividend/divisor and humidity products.
`default_nettype none
module esc_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_fire,
  input  wire logic [19:0]        in_raw_temperature,
  input  wire logic [19:0]        in_raw_pressure,
  input  wire logic [15:0]        in_raw_humidity,
  input  wire esc_pkg::esc_coef_t coef,
  output logic                    vld_o,
  output esc_pkg::esc_div_t       div_o,
  output esc_pkg::esc_side_t      side_o
);
  import esc_pkg::*;

  logic [FRONT_STAGES-1:0] vld_r;

  logic [15:0] rh_r   [1:5];
  logic [19:0] rp_r   [1:7];
  logic [15:0] temp_r [4:10];

  logic [31:0] s1_m1_r, s1_bb_r;
  logic [31:0] s2_v1_r, s2_m2_r;
  logic [31:0] s3_tf_r;
  logic [33:0] s4_q1_r;
  logic [31:0] s4_hv_r;
  logic [63:0] s5_sq_r;
  logic [49:0] s5_qp5_r, s5_qp2_r, s6_qp5_r, s6_qp2_r;
  logic [31:0] s5_hm5_r, s5_m6_r, s5_m3_r;
  logic [48:0] s6_alo_r, s6_blo_r;
  logic [31:0] s6_ahi_r, s6_bhi_r;
  logic [31:0] s6_hx_r, s6_t6_r, s6_t3_r;
  logic [63:0] s7_q2_r, s7_qb_r;
  logic [31:0] s7_y1_r, s7_hx_r;
  logic [63:0] s8_diff_r;
  logic [47:0] s8_clo_r;
  logic [31:0] s8_chi_r, s8_y3_r, s8_hx_r;
  logic [63:0] s9_den_r;
  logic [43:0] s9_n0_r;
  logic [31:0] s9_n1_r, s9_hvv_r;
  logic [63:0] s10_num_r, s10_den_r;
  logic [31:0] s10_hsq_r, s10_hvv_r;
  esc_div_t    div_r;
  esc_side_t   side_r;

  logic [31:0] d1, tb, t5, hx0, ha;
  logic [67:0] sq_full;
  logic [63:0] pa, pb, cc, cp;
  logic [20:0] prr;

  // Per-stage intermediate terms
  always_comb begin
    d1      = {15'b0, in_raw_temperature[19:3]} - {15'b0, coef.t1, 1'b0};
    tb      = {16'b0, in_raw_temperature[19:4]} - {16'b0, coef.t1};
    t5      = {s3_tf_r[29:0], 2'b0} + s3_tf_r + 32'd128;
    sq_full = 68'($signed(s4_q1_r) * $signed(s4_q1_r));
    hx0     = {2'b0, rh_r[5], 14'b0} - {coef.h4, 20'b0} - s5_hm5_r + 32'd16384;
    pa      = {{15{s6_alo_r[48]}}, s6_alo_r} + {s6_ahi_r, 32'b0};
    pb      = {{15{s6_blo_r[48]}}, s6_blo_r} + {s6_bhi_r, 32'b0};
    prr     = 21'd1048576 - {1'b0, rp_r[7]};
    cc      = 64'h0000_8000_0000_0000 + s7_qb_r;
    cp      = {16'b0, s8_clo_r} + {s8_chi_r, 32'b0};
    ha      = 32'($signed(s9_hvv_r) >>> 15);
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[FRONT_STAGES-2:0], in_fire};
    end
  end

  // Carry raw counts and temperature down the pipe
  always_ff @(posedge clk) begin
    rh_r[1] <= in_raw_humidity;
    rp_r[1] <= in_raw_pressure;
    for (int i = 2; i <= 5; i++) rh_r[i] <= rh_r[i-1];
    for (int i = 2; i <= 7; i++) rp_r[i] <= rp_r[i-1];
    temp_r[4] <= sat_s16(32'($signed(t5) >>> 8));
    for (int i = 5; i <= 10; i++) temp_r[i] <= temp_r[i-1];
  end

  // Temperature and fine temperature
  always_ff @(posedge clk) begin
    s1_m1_r <= d1 * sx32_16(coef.t2);
    s1_bb_r <= tb * tb;
    s2_v1_r <= 32'($signed(s1_m1_r) >>> 11);
    s2_m2_r <= 32'($signed(s1_bb_r) >>> 12) * sx32_16(coef.t3);
    s3_tf_r <= s2_v1_r + 32'($signed(s2_m2_r) >>> 14);
    s4_q1_r <= {s3_tf_r[31], s3_tf_r[31], s3_tf_r} - 34'd128000;
    s4_hv_r <= s3_tf_r - 32'd76800;
  end

  // Pressure dividend and divisor
  always_ff @(posedge clk) begin
    s5_sq_r   <= sq_full[63:0];
    s5_qp5_r  <= 50'($signed(s4_q1_r) * $signed(coef.p5));
    s5_qp2_r  <= 50'($signed(s4_q1_r) * $signed(coef.p2));
    s6_alo_r  <= 49'($signed({1'b0, s5_sq_r[31:0]}) * $signed(coef.p6));
    s6_ahi_r  <= s5_sq_r[63:32] * sx32_16(coef.p6);
    s6_blo_r  <= 49'($signed({1'b0, s5_sq_r[31:0]}) * $signed(coef.p3));
    s6_bhi_r  <= s5_sq_r[63:32] * sx32_16(coef.p3);
    s6_qp5_r  <= s5_qp5_r;
    s6_qp2_r  <= s5_qp2_r;
    s7_q2_r   <= pa + ({{14{s6_qp5_r[49]}}, s6_qp5_r} << 17) + (sx64_16(coef.p4) << 35);
    s7_qb_r   <= 64'($signed(pb) >>> 8) + ({{14{s6_qp2_r[49]}}, s6_qp2_r} << 12);
    s8_diff_r <= {12'b0, prr, 31'b0} - s7_q2_r;
    s8_clo_r  <= cc[31:0] * coef.p1;
    s8_chi_r  <= cc[63:32] * {16'b0, coef.p1};
    s9_den_r  <= 64'($signed(cp) >>> 33);
    s9_n0_r   <= s8_diff_r[31:0] * 12'd3125;
    s9_n1_r   <= s8_diff_r[63:32] * 32'd3125;
    s10_num_r <= {20'b0, s9_n0_r} + {s9_n1_r, 32'b0};
    s10_den_r <= s9_den_r;
  end

  // Humidity products
  always_ff @(posedge clk) begin
    s5_hm5_r  <= s4_hv_r * sx32_12(coef.h5);
    s5_m6_r   <= s4_hv_r * sx32_8(coef.h6);
    s5_m3_r   <= s4_hv_r * {24'b0, coef.h3};
    s6_hx_r   <= 32'($signed(hx0) >>> 15);
    s6_t6_r   <= 32'($signed(s5_m6_r) >>> 10);
    s6_t3_r   <= 32'($signed(s5_m3_r) >>> 11) + 32'd32768;
    s7_y1_r   <= s6_t6_r * s6_t3_r;
    s7_hx_r   <= s6_hx_r;
    s8_y3_r   <= (32'($signed(s7_y1_r) >>> 10) + 32'd2097152) * sx32_16(coef.h2)
                 + 32'd8192;
    s8_hx_r   <= s7_hx_r;
    s9_hvv_r  <= s8_hx_r * 32'($signed(s8_y3_r) >>> 14);
    s10_hsq_r <= ha * ha;
    s10_hvv_r <= s9_hvv_r;
  end

  // Fold signs into magnitudes for the divider
  always_ff @(posedge clk) begin
    div_r.rem   <= '0;
    div_r.quo   <= s10_num_r[63] ? 64'd0 - s10_num_r : s10_num_r;
    div_r.dvs   <= s10_den_r[63] ? 64'd0 - s10_den_r : s10_den_r;
    side_r.neg  <= s10_num_r[63] ^ s10_den_r[63];
    side_r.zero <= (s10_den_r == 64'd0);
    side_r.hm   <= 32'($signed(s10_hsq_r) >>> 7) * {24'b0, coef.h1};
    side_r.hvv  <= s10_hvv_r;
    side_r.temp <= temp_r[10];
  end

  assign vld_o  = vld_r[FRONT_STAGES-1];
  assign div_o  = div_r;
  assign side_o = side_r;

endmodule
`default_nettype wire

### rtl/core/esc_post.sv
// Back pipeline: pressure correction terms, saturation and humidity scaling.
`default_nettype none
module esc_post (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               vld_i,
  input  wire esc_pkg::esc_div_t  div_i,
  input  wire esc_pkg::esc_side_t side_i,
  input  wire esc_pkg::esc_coef_t coef,
  output logic                    strobe_o,
  output logic [15:0]             temp_o,
  output logic [23:0]             pres_o,
  output logic                    pvalid_o,
  output logic [13:0]             hum_o
);
  import esc_pkg::*;

  logic [POST_STAGES-1:0] vld_r;
  logic [15:0] temp_r [1:7];
  logic [13:0] hum_r  [1:7];
  logic        zero_r [1:7];
  logic [63:0] pr_r   [1:5];
  logic [63:0] ssl_r, s2_r, q2a_r, q2b_r, q2c_r, q1_r, pr2_r;
  logic [31:0] ssh_r, p8hi_r, m9hi_r;
  logic [48:0] p8lo_r, m9lo_r;
  logic [23:0] pres_r;

  logic [31:0] hd, hc;
  logic [16:0] hs;
  logic [23:0] h100;
  logic [63:0] s, p8s, m9s, ps;

  // Humidity finish and correction sums
  always_comb begin
    hd = side_i.hvv - 32'($signed(side_i.hm) >>> 4);
    if (hd[31]) begin
      hc = 32'd0;
    end else if (hd > 32'd419430400) begin
      hc = 32'd419430400;
    end else begin
      hc = hd;
    end
    hs   = hc[28:12];
    h100 = {1'b0, hs, 6'b0} + {2'b0, hs, 5'b0} + {5'b0, hs, 2'b0};
    s    = 64'($signed(pr_r[1]) >>> 13);
    p8s  = {{15{p8lo_r[48]}}, p8lo_r} + {p8hi_r, 32'b0};
    m9s  = {{15{m9lo_r[48]}}, m9lo_r} + {m9hi_r, 32'b0};
    ps   = 64'($signed(pr2_r) >>> 8);
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[POST_STAGES-2:0], vld_i};
    end
  end

  // Carry side data
  always_ff @(posedge clk) begin
    temp_r[1] <= side_i.temp;
    hum_r[1]  <= h100[23:10];
    zero_r[1] <= side_i.zero;
    pr_r[1]   <= side_i.neg ? 64'd0 - div_i.quo : div_i.quo;
    for (int i = 2; i <= 7; i++) begin
      temp_r[i] <= temp_r[i-1];
      hum_r[i]  <= hum_r[i-1];
      zero_r[i] <= zero_r[i-1];
    end
    for (int i = 2; i <= 5; i++) pr_r[i] <= pr_r[i-1];
  end

  // Pressure correction
  always_ff @(posedge clk) begin
    ssl_r  <= s[31:0] * s[31:0];
    ssh_r  <= s[31:0] * s[63:32];
    p8lo_r <= 49'($signed({1'b0, pr_r[1][31:0]}) * $signed(coef.p8));
    p8hi_r <= pr_r[1][63:32] * sx32_16(coef.p8);
    s2_r   <= ssl_r + {ssh_r[30:0], 33'b0};
    q2a_r  <= 64'($signed(p8s) >>> 19);
    m9lo_r <= 49'($signed({1'b0, s2_r[31:0]}) * $signed(coef.p9));
    m9hi_r <= s2_r[63:32] * sx32_16(coef.p9);
    q2b_r  <= q2a_r;
    q1_r   <= 64'($signed(m9s) >>> 25);
    q2c_r  <= q2b_r;
    pr2_r  <= 64'($signed(pr_r[5] + q1_r + q2c_r) >>> 8) + (sx64_16(coef.p7) << 4);
    if (zero_r[6] || ps[63]) begin
      pres_r <= 24'd0;
    end else if (|ps[62:24]) begin
      pres_r <= 24'hff_ffff;
    end else begin
      pres_r <= ps[23:0];
    end
  end

  assign strobe_o = vld_r[POST_STAGES-1];
  assign temp_o   = temp_r[7];
  assign hum_o    = hum_r[7];
  assign pvalid_o = ~zero_r[7];
  assign pres_o   = pres_r;

endmodule
`default_nettype wire

### rtl/core/env_sensor_compensation.sv
// Top level of the sensor compensation pipeline with its calibration registers.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------------
//  input    | start / busy            | in_raw_temperature, in_raw_pressure, in_raw_humidity
//  result   | out_strobe              | out_temperature_centi_c, out_pressure_pa,
//           |                         | out_pressure_valid, out_humidity_centi_rh
//  config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One sample enters every cycle; busy stays low.
// Each sample passes through 11 front stages, a 64-cell divide chain (one quotient bit
// per cell) and 7 back stages before its result appears.
// Synchronous active-low reset clears the calibration registers and all stage valids.
// The receiver cannot stall; each result is shown for one cycle only.
`default_nettype none
`include "env_sensor_compensation_macros.svh"
module env_sensor_compensation (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [19:0]        in_raw_temperature,
  input  wire logic [19:0]        in_raw_pressure,
  input  wire logic [15:0]        in_raw_humidity,
  output logic                    out_strobe,
  output logic signed [15:0]      out_temperature_centi_c,
  output logic [23:0]             out_pressure_pa,
  output logic                    out_pressure_valid,
  output logic [13:0]             out_humidity_centi_rh,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [63:0]        cfg_data
);
  import esc_pkg::*;

  logic [47:0] temp_coef_r;
  logic [63:0] pres_lo_r, pres_hi_r, hum_coef_r;
  logic [15:0] pres_p9_r;
  esc_coef_t   coef;
  logic        in_fire;
  logic        f_vld, d_vld;
  esc_div_t    f_div, d_div;
  esc_side_t   f_side, d_side;
  logic [15:0] temp_w;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_fire   = start & ~busy;

  // Write calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coef_r <= '0;
      pres_lo_r   <= '0;
      pres_hi_r   <= '0;
      pres_p9_r   <= '0;
      hum_coef_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (esc_reg_t'(cfg_index))
        REG_TEMP:    temp_coef_r <= cfg_data[47:0];
        REG_PRES_LO: pres_lo_r   <= cfg_data;
        REG_PRES_HI: pres_hi_r   <= cfg_data;
        REG_PRES_P9: pres_p9_r   <= cfg_data[15:0];
        REG_HUM:     hum_coef_r  <= cfg_data;
        default:     ;
      endcase
    end
  end

  // Unpack coefficients
  always_comb begin
    coef.t1 = temp_coef_r[15:0];
    coef.t2 = temp_coef_r[31:16];
    coef.t3 = temp_coef_r[47:32];
    coef.p1 = pres_lo_r[15:0];
    coef.p2 = pres_lo_r[31:16];
    coef.p3 = pres_lo_r[47:32];
    coef.p4 = pres_lo_r[63:48];
    coef.p5 = pres_hi_r[15:0];
    coef.p6 = pres_hi_r[31:16];
    coef.p7 = pres_hi_r[47:32];
    coef.p8 = pres_hi_r[63:48];
    coef.p9 = pres_p9_r;
    coef.h1 = hum_coef_r[7:0];
    coef.h2 = hum_coef_r[23:8];
    coef.h3 = hum_coef_r[31:24];
    coef.h4 = hum_coef_r[43:32];
    coef.h5 = hum_coef_r[55:44];
    coef.h6 = hum_coef_r[63:56];
  end

  esc_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_fire            (in_fire),
    .in_raw_temperature (in_raw_temperature),
    .in_raw_pressure    (in_raw_pressure),
    .in_raw_humidity    (in_raw_humidity),
    .coef               (coef),
    .vld_o              (f_vld),
    .div_o              (f_div),
    .side_o             (f_side)
  );

  esc_divider u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (f_vld),
    .div_i  (f_div),
    .side_i (f_side),
    .vld_o  (d_vld),
    .div_o  (d_div),
    .side_o (d_side)
  );

  esc_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_i    (d_vld),
    .div_i    (d_div),
    .side_i   (d_side),
    .coef     (coef),
    .strobe_o (out_strobe),
    .temp_o   (temp_w),
    .pres_o   (out_pressure_pa),
    .pvalid_o (out_pressure_valid),
    .hum_o    (out_humidity_centi_rh)
  );

  assign out_temperature_centi_c = $signed(temp_w);

  `ESC_ASSERT_IMP(a_latency, start && !busy, ##ESC_LATENCY out_strobe, "result beat missing")
  `ESC_ASSERT_IMP(a_origin, out_strobe, $past(start && !busy, ESC_LATENCY), "unexpected result beat")
  `ESC_ASSERT_IMP(a_pzero, out_strobe && !out_pressure_valid, out_pressure_pa == 24'd0, "pressure not zeroed")
  `ESC_ASSERT_NEVER(a_hum_range, out_strobe && (out_humidity_centi_rh > 14'd10000), "humidity out of range")

endmodule
`default_nettype wire
